// File: src/cspe_pkg.sv
`default_nettype none
package cspe_pkg;

  localparam int MAX_KNOTS  = 1024;
  localparam int IDX_W      = $clog2(MAX_KNOTS);
  localparam int CNT_W      = 11;
  localparam int COORD_W    = 16;
  localparam int U_W        = 17;
  localparam int KNOT_W     = 3 * COORD_W;
  localparam int PIPE_DEPTH = 6;

  // datapath widths: weights at 2^-48 scale, control values at twice the grid
  localparam int W_W     = 54;
  localparam int B_W     = COORD_W + 3;
  localparam int WL_W    = 26;
  localparam int WH_W    = W_W - WL_W;
  localparam int PH_W    = WH_W + B_W;
  localparam int PL_W    = WL_W + 1 + B_W;
  localparam int ACC_W   = 80;
  localparam int SHIFT   = 50;

  localparam logic [U_W-1:0] U_ONE = U_W'(65536);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic MODE_HERMITE = 1'b0;
  localparam logic MODE_CR      = 1'b1;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [W_W-1:0]     w_t;
  typedef logic signed [B_W-1:0]     b_t;
  typedef logic signed [3:0]         coef_t;
  typedef logic signed [PH_W-1:0]    ph_t;
  typedef logic signed [PL_W-1:0]    pl_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FEW   = 2'd2
  } status_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } knot_t;

  typedef struct packed {
    logic             operation;
    logic [IDX_W-1:0] knot_index;
    coord_t           point_x;
    coord_t           point_y;
    coord_t           point_z;
    coord_t           tangent_x;
    coord_t           tangent_y;
    coord_t           tangent_z;
    logic [U_W-1:0]   param_u;
  } in_item_t;

  typedef struct packed {
    coord_t  curve_x;
    coord_t  curve_y;
    coord_t  curve_z;
    status_t status;
  } out_item_t;

  typedef struct packed {
    logic mode;
    logic kzero;
  } fetch_ctl_t;

  typedef struct packed {
    logic    valid;
    logic    ok;
    status_t status;
  } meta_t;

  // basis matrices scaled by two, row-major, row 0 multiplies u^3
  localparam coef_t BASIS_CR [16] = '{
    -4'sd1,  4'sd3, -4'sd3,  4'sd1,
     4'sd2, -4'sd5,  4'sd4, -4'sd1,
    -4'sd1,  4'sd0,  4'sd1,  4'sd0,
     4'sd0,  4'sd2,  4'sd0,  4'sd0
  };
  localparam coef_t BASIS_HE [16] = '{
     4'sd4, -4'sd4,  4'sd2,  4'sd2,
    -4'sd6,  4'sd6, -4'sd4, -4'sd2,
     4'sd0,  4'sd0,  4'sd2,  4'sd0,
     4'sd2,  4'sd0,  4'sd0,  4'sd0
  };

  function automatic coef_t basis(input logic mode, input int unsigned idx);
    coef_t c;
    if (mode == MODE_CR) begin
      c = BASIS_CR[idx];
    end else begin
      c = BASIS_HE[idx];
    end
    return c;
  endfunction

  function automatic coord_t axis(input knot_t p, input int unsigned a);
    coord_t c;
    case (a)
      0: c = p.x;
      1: c = p.y;
      default: c = p.z;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/cubic_spline_point_evaluator_top.sv
`default_nettype none
// Cubic spline point evaluator, Catmull-Rom or cubic Hermite. One item (knot
// load or curve evaluate) is taken every clock; busy never rises. Each item
// yields exactly one result, strobed on out_valid, in order. The receiver has
// no way to stall: results must be taken the cycle they appear. The depth comes
// from the registered knot memories, the u^2 and u^3 multiplier stages, the
// weight stage, the product stage and the rounding stage. A load is visible to
// an evaluate in the next cycle.
// Write curve_mode and point_count only while no results are pending.
module cubic_spline_point_evaluator_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire cspe_pkg::in_item_t        in_item,
  output logic                           out_valid,
  output cspe_pkg::out_item_t            out_item,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [cspe_pkg::CNT_W-1:0] cfg_wdata
);

  logic                        curve_mode_r;
  logic [cspe_pkg::CNT_W-1:0]  point_count_r;
  cspe_pkg::meta_t             meta_r [cspe_pkg::PIPE_DEPTH];
  cspe_pkg::meta_t             meta_nxt;
  logic [cspe_pkg::U_W-1:0]    u_s1_r;
  cspe_pkg::fetch_ctl_t        ctl_s1_r;
  cspe_pkg::b_t                b_s2 [3][4];
  cspe_pkg::b_t                b_d1_r [3][4];
  cspe_pkg::b_t                b_d2_r [3][4];
  cspe_pkg::w_t                w_s4 [4];
  cspe_pkg::coord_t            res [3];

  logic                        accept;
  logic                        wr_en;
  logic [cspe_pkg::CNT_W-1:0]  n, kk, e1, e, f1, f;
  logic [cspe_pkg::IDX_W-1:0]  km1;
  logic [cspe_pkg::U_W-1:0]    u_c;
  cspe_pkg::knot_t             knot_w, tan_w;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_mode_r  <= cspe_pkg::MODE_CR;
      point_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cspe_pkg::CFG_MODE:  curve_mode_r  <= cfg_wdata[0];
        cspe_pkg::CFG_COUNT: point_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    n  = (point_count_r > cspe_pkg::CNT_W'(cspe_pkg::MAX_KNOTS))
       ? cspe_pkg::CNT_W'(cspe_pkg::MAX_KNOTS) : point_count_r;
    kk = cspe_pkg::CNT_W'(in_item.knot_index);
    e1 = kk + cspe_pkg::CNT_W'(1);
    e  = (e1 >= n) ? '0 : e1;
    f1 = e + cspe_pkg::CNT_W'(1);
    f  = (f1 >= n) ? '0 : f1;
    km1 = in_item.knot_index - cspe_pkg::IDX_W'(1);
    u_c = (in_item.param_u > cspe_pkg::U_ONE) ? cspe_pkg::U_ONE : in_item.param_u;
    knot_w = {in_item.point_x, in_item.point_y, in_item.point_z};
    tan_w  = {in_item.tangent_x, in_item.tangent_y, in_item.tangent_z};

    meta_nxt.valid  = accept;
    meta_nxt.ok     = 1'b0;
    meta_nxt.status = cspe_pkg::ST_OK;
    wr_en           = 1'b0;
    if (in_item.operation == cspe_pkg::OP_LOAD) begin
      if (kk >= cspe_pkg::CNT_W'(cspe_pkg::MAX_KNOTS)) begin
        meta_nxt.status = cspe_pkg::ST_RANGE;
      end else begin
        wr_en = accept;
      end
    end else if (n < cspe_pkg::CNT_W'(3)) begin
      meta_nxt.status = cspe_pkg::ST_FEW;
    end else if (kk >= n) begin
      meta_nxt.status = cspe_pkg::ST_RANGE;
    end else begin
      meta_nxt.ok = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < cspe_pkg::PIPE_DEPTH; s++) begin
        meta_r[s] <= '0;
      end
    end else begin
      meta_r[0] <= meta_nxt;
      for (int s = 1; s < cspe_pkg::PIPE_DEPTH; s++) begin
        meta_r[s] <= meta_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    u_s1_r         <= u_c;
    ctl_s1_r.mode  <= curve_mode_r;
    ctl_s1_r.kzero <= (in_item.knot_index == '0);
    b_d1_r         <= b_s2;
    b_d2_r         <= b_d1_r;
  end

  cspe_fetch u_fetch (
    .clk        (clk),
    .we         (wr_en),
    .waddr      (in_item.knot_index),
    .knot_wdata (knot_w),
    .tan_wdata  (tan_w),
    .addr_km1   (km1),
    .addr_k     (in_item.knot_index),
    .addr_e     (e[cspe_pkg::IDX_W-1:0]),
    .addr_f     (f[cspe_pkg::IDX_W-1:0]),
    .ctl        (ctl_s1_r),
    .b_r        (b_s2)
  );

  cspe_weight u_weight (
    .clk  (clk),
    .u    (u_s1_r),
    .mode (ctl_s1_r.mode),
    .w_r  (w_s4)
  );

  cspe_combine u_combine (
    .clk   (clk),
    .w     (w_s4),
    .b     (b_d2_r),
    .res_r (res)
  );

  always_comb begin
    out_valid       = meta_r[cspe_pkg::PIPE_DEPTH-1].valid;
    out_item.status = meta_r[cspe_pkg::PIPE_DEPTH-1].status;
    if (meta_r[cspe_pkg::PIPE_DEPTH-1].ok) begin
      out_item.curve_x = res[0];
      out_item.curve_y = res[1];
      out_item.curve_z = res[2];
    end else begin
      out_item.curve_x = '0;
      out_item.curve_y = '0;
      out_item.curve_z = '0;
    end
  end

endmodule
`default_nettype wire

// File: src/cspe_ram.sv
`default_nettype none
module cspe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/cspe_fetch.sv
`default_nettype none
module cspe_fetch (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [cspe_pkg::IDX_W-1:0]   waddr,
  input  wire cspe_pkg::knot_t              knot_wdata,
  input  wire cspe_pkg::knot_t              tan_wdata,
  input  wire logic [cspe_pkg::IDX_W-1:0]   addr_km1,
  input  wire logic [cspe_pkg::IDX_W-1:0]   addr_k,
  input  wire logic [cspe_pkg::IDX_W-1:0]   addr_e,
  input  wire logic [cspe_pkg::IDX_W-1:0]   addr_f,
  input  wire cspe_pkg::fetch_ctl_t         ctl,
  output cspe_pkg::b_t                      b_r [3][4]
);

  cspe_pkg::knot_t pkm1, pk, pe, pf, tk, te;
  cspe_pkg::b_t    b_nxt [3][4];
  cspe_pkg::b_t    vkm1, vk, ve, vf, vtk, vte;

  // one replica per read port, all written together
  cspe_ram #(.WIDTH(cspe_pkg::KNOT_W), .DEPTH(cspe_pkg::MAX_KNOTS)) u_ram_km1 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(knot_wdata), .raddr(addr_km1), .rdata_r(pkm1));
  cspe_ram #(.WIDTH(cspe_pkg::KNOT_W), .DEPTH(cspe_pkg::MAX_KNOTS)) u_ram_k (
    .clk(clk), .we(we), .waddr(waddr), .wdata(knot_wdata), .raddr(addr_k), .rdata_r(pk));
  cspe_ram #(.WIDTH(cspe_pkg::KNOT_W), .DEPTH(cspe_pkg::MAX_KNOTS)) u_ram_e (
    .clk(clk), .we(we), .waddr(waddr), .wdata(knot_wdata), .raddr(addr_e), .rdata_r(pe));
  cspe_ram #(.WIDTH(cspe_pkg::KNOT_W), .DEPTH(cspe_pkg::MAX_KNOTS)) u_ram_f (
    .clk(clk), .we(we), .waddr(waddr), .wdata(knot_wdata), .raddr(addr_f), .rdata_r(pf));
  cspe_ram #(.WIDTH(cspe_pkg::KNOT_W), .DEPTH(cspe_pkg::MAX_KNOTS)) u_ram_tk (
    .clk(clk), .we(we), .waddr(waddr), .wdata(tan_wdata), .raddr(addr_k), .rdata_r(tk));
  cspe_ram #(.WIDTH(cspe_pkg::KNOT_W), .DEPTH(cspe_pkg::MAX_KNOTS)) u_ram_te (
    .clk(clk), .we(we), .waddr(waddr), .wdata(tan_wdata), .raddr(addr_e), .rdata_r(te));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vkm1 = cspe_pkg::b_t'(cspe_pkg::axis(pkm1, a));
      vk   = cspe_pkg::b_t'(cspe_pkg::axis(pk, a));
      ve   = cspe_pkg::b_t'(cspe_pkg::axis(pe, a));
      vf   = cspe_pkg::b_t'(cspe_pkg::axis(pf, a));
      vtk  = cspe_pkg::b_t'(cspe_pkg::axis(tk, a));
      vte  = cspe_pkg::b_t'(cspe_pkg::axis(te, a));
      if (ctl.mode == cspe_pkg::MODE_CR) begin
        // at knot 0, e and f are knots 1 and 2: extrapolated history
        if (ctl.kzero) begin
          b_nxt[a][0] = ve + (ve <<< 1) - (vf <<< 1) - (vk <<< 1);
        end else begin
          b_nxt[a][0] = vkm1 <<< 1;
        end
        b_nxt[a][1] = vk <<< 1;
        b_nxt[a][2] = ve <<< 1;
        b_nxt[a][3] = vf <<< 1;
      end else begin
        b_nxt[a][0] = vk <<< 1;
        b_nxt[a][1] = ve <<< 1;
        b_nxt[a][2] = vtk <<< 1;
        b_nxt[a][3] = vte <<< 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_r <= b_nxt;
  end

endmodule
`default_nettype wire

// File: src/cspe_weight.sv
`default_nettype none
module cspe_weight (
  input  wire logic                       clk,
  input  wire logic [cspe_pkg::U_W-1:0]   u,
  input  wire logic                       mode,
  output cspe_pkg::w_t                    w_r [4]
);

  localparam int U2_W = 2 * cspe_pkg::U_W - 1;
  localparam int U3_W = 3 * cspe_pkg::U_W - 2;

  logic [cspe_pkg::U_W-1:0] u_a_r, u_b_r;
  logic [U2_W-1:0]          u2_a_r, u2_b_r;
  logic [U3_W-1:0]          u3_b_r;
  logic                     mode_a_r, mode_b_r;
  logic [U2_W-1:0]          sq;
  logic [U2_W+U3_W-1:0]     cu;
  cspe_pkg::w_t             row [4];
  cspe_pkg::w_t             w_nxt [4];

  // u is at most 65536, so u^2 fits U2_W bits
  assign sq = {{(U2_W-cspe_pkg::U_W){1'b0}}, u} * {{(U2_W-cspe_pkg::U_W){1'b0}}, u};
  assign cu = {{U3_W{1'b0}}, u2_a_r} * {{(U2_W+U3_W-cspe_pkg::U_W){1'b0}}, u_a_r};

  // row [u^3 u^2 u 1] at a common 2^-48 scale
  always_comb begin
    row[0] = cspe_pkg::w_t'(u3_b_r);
    row[1] = cspe_pkg::w_t'({u2_b_r, 16'd0});
    row[2] = cspe_pkg::w_t'({u_b_r, 32'd0});
    row[3] = cspe_pkg::w_t'(1) <<< 48;
    for (int j = 0; j < 4; j++) begin
      w_nxt[j] = '0;
      for (int i = 0; i < 4; i++) begin
        w_nxt[j] = w_nxt[j]
                 + row[i] * cspe_pkg::w_t'(cspe_pkg::basis(mode_b_r, i * 4 + j));
      end
    end
  end

  always_ff @(posedge clk) begin
    u_a_r    <= u;
    u2_a_r   <= sq;
    mode_a_r <= mode;
    u_b_r    <= u_a_r;
    u2_b_r   <= u2_a_r;
    u3_b_r   <= cu[U3_W-1:0];
    mode_b_r <= mode_a_r;
    w_r      <= w_nxt;
  end

endmodule
`default_nettype wire

// File: src/cspe_combine.sv
`default_nettype none
module cspe_combine (
  input  wire logic          clk,
  input  wire cspe_pkg::w_t  w [4],
  input  wire cspe_pkg::b_t  b [3][4],
  output cspe_pkg::coord_t   res_r [3]
);

  cspe_pkg::ph_t    ph_r [3][4];
  cspe_pkg::pl_t    pl_r [3][4];
  cspe_pkg::ph_t    ph_nxt [3][4];
  cspe_pkg::pl_t    pl_nxt [3][4];
  cspe_pkg::coord_t res_nxt [3];
  cspe_pkg::acc_t   acc;
  cspe_pkg::acc_t   q;
  logic signed [cspe_pkg::WH_W-1:0] wh;
  logic signed [cspe_pkg::WL_W:0]   wl;

  localparam cspe_pkg::acc_t HI = cspe_pkg::acc_t'((1 << (cspe_pkg::COORD_W - 1)) - 1);
  localparam cspe_pkg::acc_t LO = -HI - cspe_pkg::acc_t'(1);

  // weight split into high and low halves keeps each multiply narrow
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 4; j++) begin
        wh = w[j][cspe_pkg::W_W-1:cspe_pkg::WL_W];
        wl = {1'b0, w[j][cspe_pkg::WL_W-1:0]};
        ph_nxt[a][j] = cspe_pkg::ph_t'(wh) * cspe_pkg::ph_t'(b[a][j]);
        pl_nxt[a][j] = cspe_pkg::pl_t'(wl) * cspe_pkg::pl_t'(b[a][j]);
      end
    end
  end

  // exact sum, round half up, saturate
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc = cspe_pkg::acc_t'(1) <<< (cspe_pkg::SHIFT - 1);
      for (int j = 0; j < 4; j++) begin
        acc = acc + (cspe_pkg::acc_t'(ph_r[a][j]) <<< cspe_pkg::WL_W)
                  + cspe_pkg::acc_t'(pl_r[a][j]);
      end
      q = acc >>> cspe_pkg::SHIFT;
      if (q > HI) begin
        res_nxt[a] = HI[cspe_pkg::COORD_W-1:0];
      end else if (q < LO) begin
        res_nxt[a] = LO[cspe_pkg::COORD_W-1:0];
      end else begin
        res_nxt[a] = q[cspe_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ph_r  <= ph_nxt;
    pl_r  <= pl_nxt;
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// File: dv/cspe_checker.sv
`timescale 1ns / 1ps
module cspe_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  cspe_pkg::in_item_t            in_item,
  input  logic                          out_valid,
  input  cspe_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [cspe_pkg::CNT_W-1:0]    cfg_wdata,
  output int                            fails,
  output int                            pending
);

  typedef logic signed [127:0] wide_t;

  // doubled basis matrices, row 0 multiplies u^3
  localparam int CR2[16] = '{-1, 3, -3, 1, 2, -5, 4, -1, -1, 0, 1, 0, 0, 2, 0, 0};
  localparam int HE2[16] = '{4, -4, 2, 2, -6, 6, -4, -2, 0, 0, 2, 0, 2, 0, 0, 0};

  cspe_pkg::coord_t          knot_mem[cspe_pkg::MAX_KNOTS][3];
  cspe_pkg::coord_t          tan_mem[cspe_pkg::MAX_KNOTS][3];
  logic                      mode_q;
  logic [cspe_pkg::CNT_W-1:0] count_q;
  cspe_pkg::out_item_t       curve_q[$];

  function automatic cspe_pkg::coord_t round_sat(wide_t acc);
    wide_t r;
    r = (acc + (wide_t'(1) <<< 49)) >>> 50;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return cspe_pkg::coord_t'(r[15:0]);
  endfunction

  function automatic cspe_pkg::out_item_t eval_point(logic [cspe_pkg::IDX_W-1:0] k,
                                                     logic [cspe_pkg::U_W-1:0] u_in);
    cspe_pkg::out_item_t res;
    int unsigned n, e, f, kk;
    wide_t       uu, acc;
    wide_t       row[4], w[4], b[4];
    res = '0;
    res.status = cspe_pkg::ST_OK;
    kk = k;
    n = (count_q > cspe_pkg::MAX_KNOTS) ? cspe_pkg::MAX_KNOTS : count_q;
    if (n < 3) begin
      res.status = cspe_pkg::ST_FEW;
      return res;
    end
    if (kk >= n) begin
      res.status = cspe_pkg::ST_RANGE;
      return res;
    end
    uu = (u_in > cspe_pkg::U_ONE) ? wide_t'(65536) : wide_t'(u_in);
    row[0] = uu * uu * uu;
    row[1] = (uu * uu) <<< 16;
    row[2] = uu <<< 32;
    row[3] = wide_t'(1) <<< 48;
    e = (kk + 1 >= n) ? 0 : kk + 1;
    f = (e + 1 >= n) ? 0 : e + 1;
    for (int j = 0; j < 4; j++) begin
      w[j] = 0;
      for (int i = 0; i < 4; i++)
        w[j] += row[i] * ((mode_q == cspe_pkg::MODE_CR) ? CR2[i*4+j] : HE2[i*4+j]);
    end
    for (int a = 0; a < 3; a++) begin
      if (mode_q == cspe_pkg::MODE_CR) begin
        // knot 0 has no predecessor: extrapolated history point
        if (kk > 0) b[0] = 2 * wide_t'(knot_mem[kk-1][a]);
        else b[0] = 3 * wide_t'(knot_mem[1][a]) - 2 * wide_t'(knot_mem[2][a])
                    - 2 * wide_t'(knot_mem[0][a]);
        b[1] = 2 * wide_t'(knot_mem[kk][a]);
        b[2] = 2 * wide_t'(knot_mem[e][a]);
        b[3] = 2 * wide_t'(knot_mem[f][a]);
      end else begin
        b[0] = 2 * wide_t'(knot_mem[kk][a]);
        b[1] = 2 * wide_t'(knot_mem[e][a]);
        b[2] = 2 * wide_t'(tan_mem[kk][a]);
        b[3] = 2 * wide_t'(tan_mem[e][a]);
      end
      acc = 0;
      for (int j = 0; j < 4; j++) acc += w[j] * b[j];
      case (a)
        0: res.curve_x = round_sat(acc);
        1: res.curve_y = round_sat(acc);
        default: res.curve_z = round_sat(acc);
      endcase
    end
    return res;
  endfunction

  assign pending = curve_q.size();

  always @(posedge clk) begin
    cspe_pkg::out_item_t exp_r;
    if (!rst_n) begin
      mode_q  <= cspe_pkg::MODE_CR;
      count_q <= '0;
      fails   <= 0;
      curve_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == cspe_pkg::CFG_MODE) mode_q <= cfg_wdata[0];
        else count_q <= cfg_wdata;
      end
      if (start && !busy) begin
        if (in_item.operation == cspe_pkg::OP_LOAD) begin
          knot_mem[in_item.knot_index][0] = in_item.point_x;
          knot_mem[in_item.knot_index][1] = in_item.point_y;
          knot_mem[in_item.knot_index][2] = in_item.point_z;
          tan_mem[in_item.knot_index][0]  = in_item.tangent_x;
          tan_mem[in_item.knot_index][1]  = in_item.tangent_y;
          tan_mem[in_item.knot_index][2]  = in_item.tangent_z;
          exp_r = '0;
          exp_r.status = cspe_pkg::ST_OK;
        end else begin
          exp_r = eval_point(in_item.knot_index, in_item.param_u);
        end
        curve_q = {curve_q, exp_r};
      end
      if (out_valid) begin
        if (curve_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails <= fails + 1;
        end else begin
          exp_r = curve_q.pop_front();
          if (out_item !== exp_r) begin
            if (out_item.curve_x !== exp_r.curve_x)
              $error("curve_x expected %0d got %0d", exp_r.curve_x, out_item.curve_x);
            if (out_item.curve_y !== exp_r.curve_y)
              $error("curve_y expected %0d got %0d", exp_r.curve_y, out_item.curve_y);
            if (out_item.curve_z !== exp_r.curve_z)
              $error("curve_z expected %0d got %0d", exp_r.curve_z, out_item.curve_z);
            if (out_item.status !== exp_r.status)
              $error("status expected %0d got %0d", exp_r.status, out_item.status);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

// File: dv/cubic_spline_point_evaluator_top_tb.sv
`timescale 1ns / 1ps
module cubic_spline_point_evaluator_top_tb;

  localparam int STALL_LIMIT = 2000;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  cspe_pkg::in_item_t         in_item;
  logic                       out_valid;
  cspe_pkg::out_item_t        out_item;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [cspe_pkg::CNT_W-1:0] cfg_wdata;
  int                         fails;
  int                         pending;
  int                         idle_cycles;
  int                         n_loads, n_evals, n_settings;
  bit                         loaded[cspe_pkg::MAX_KNOTS];

  cubic_spline_point_evaluator_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  cspe_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("cubic_spline_point_evaluator_top_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic cspe_pkg::coord_t rand_coord();
    cspe_pkg::coord_t c;
    c = cspe_pkg::coord_t'($urandom);
    if ($urandom_range(1) == 1) c = c >>> 3;
    return c;
  endfunction

  function automatic logic [cspe_pkg::U_W-1:0] rand_u();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return cspe_pkg::U_W'($urandom_range(0, 65536));
    if (r < 85) return '0;
    if (r < 90) return cspe_pkg::U_ONE;
    return cspe_pkg::U_W'($urandom_range(65537, 131071));
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send(cspe_pkg::in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (it.operation == cspe_pkg::OP_LOAD) begin
      loaded[it.knot_index] = 1'b1;
      n_loads++;
    end else begin
      n_evals++;
    end
  endtask

  task automatic pause(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic load_knot(logic [cspe_pkg::IDX_W-1:0] k, cspe_pkg::coord_t p,
                           cspe_pkg::coord_t t);
    cspe_pkg::in_item_t it;
    it = '0;
    it.operation = cspe_pkg::OP_LOAD;
    it.knot_index = k;
    it.point_x = p; it.point_y = -p; it.point_z = p >>> 1;
    it.tangent_x = t; it.tangent_y = ~t; it.tangent_z = p;
    it.param_u = cspe_pkg::U_W'($urandom);
    send(it);
  endtask

  task automatic load_rand(logic [cspe_pkg::IDX_W-1:0] k);
    cspe_pkg::in_item_t it;
    it.operation = cspe_pkg::OP_LOAD;
    it.knot_index = k;
    it.point_x = rand_coord(); it.point_y = rand_coord(); it.point_z = rand_coord();
    it.tangent_x = rand_coord(); it.tangent_y = rand_coord();
    it.tangent_z = rand_coord();
    it.param_u = cspe_pkg::U_W'($urandom);
    send(it);
  endtask

  task automatic evaluate(logic [cspe_pkg::IDX_W-1:0] k, logic [cspe_pkg::U_W-1:0] u);
    cspe_pkg::in_item_t it;
    it.operation = cspe_pkg::OP_EVAL;
    it.knot_index = k;
    it.point_x = rand_coord(); it.point_y = rand_coord(); it.point_z = rand_coord();
    it.tangent_x = rand_coord(); it.tangent_y = rand_coord();
    it.tangent_z = rand_coord();
    it.param_u = u;
    send(it);
  endtask

  // wait for every result, then let the pipeline drain
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // cfg_we is dropped again after each write, before the task returns
  task automatic write_reg(logic idx, logic [cspe_pkg::CNT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(logic mode, int unsigned count, int unsigned n_items,
                           int unsigned idle_pct);
    int unsigned n, r;
    settle();
    write_reg(cspe_pkg::CFG_MODE, cspe_pkg::CNT_W'(mode));
    write_reg(cspe_pkg::CFG_COUNT, cspe_pkg::CNT_W'(count));
    n_settings++;
    n = (count > cspe_pkg::MAX_KNOTS) ? cspe_pkg::MAX_KNOTS : count;
    // every knot below the count must be written before any evaluate reads it
    for (int i = 0; i < n; i++) begin
      if (!loaded[i]) begin
        load_rand(cspe_pkg::IDX_W'(i));
        pause(idle_pct);
      end
    end
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 72 && n > 0)
        evaluate(cspe_pkg::IDX_W'($urandom_range(0, n - 1)), rand_u());
      else if (r < 82) evaluate(cspe_pkg::IDX_W'($urandom), rand_u());
      else load_rand(cspe_pkg::IDX_W'($urandom));
      pause(idle_pct);
    end
  endtask

  initial begin
    int unsigned cnt, pct;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = cspe_pkg::CFG_MODE;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    n_loads = 0; n_evals = 0; n_settings = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty table, extremes, history knot, wrap, range, clamp of u
    evaluate(10'd0, cspe_pkg::U_ONE);
    load_knot(10'd0, 16'sh7fff, 16'sh8000);
    load_knot(10'd1, 16'sh8000, 16'sh7fff);
    load_knot(10'd2, 16'sh0000, 16'sh8000);
    load_knot(10'd3, 16'sh7fff, 16'sh0001);
    load_knot(10'd4, 16'sh1234, 16'shedcb);
    settle();
    write_reg(cspe_pkg::CFG_COUNT, cspe_pkg::CNT_W'(2));
    evaluate(10'd0, 17'd32768);
    settle();
    write_reg(cspe_pkg::CFG_COUNT, cspe_pkg::CNT_W'(5));
    evaluate(10'd0, '0);
    evaluate(10'd0, cspe_pkg::U_ONE);
    evaluate(10'd4, 17'd32768);
    evaluate(10'd3, 17'h1ffff);
    evaluate(10'd5, 17'd100);
    evaluate(10'h3ff, 17'd100);
    evaluate(10'd2, 17'd1);
    evaluate(10'd1, 17'd65535);
    settle();
    write_reg(cspe_pkg::CFG_MODE, cspe_pkg::CNT_W'(cspe_pkg::MODE_HERMITE));
    evaluate(10'd4, 17'd40000);
    evaluate(10'd0, cspe_pkg::U_ONE);
    evaluate(10'd1, '0);
    evaluate(10'd3, 17'h10001);
    evaluate(10'd2, 17'd21845);

    for (int p = 0; p < 12; p++) begin
      case (p)
        1: cnt = 3;
        3: cnt = cspe_pkg::MAX_KNOTS;
        5: cnt = $urandom_range(0, 2);
        7: cnt = 2047;
        default: cnt = $urandom_range(3, 48);
      endcase
      case (p % 3)
        0: pct = 0;
        1: pct = 76;
        default: pct = 28;
      endcase
      run_phase(((p % 2) == 1) ^ ($urandom_range(3) == 0), cnt, 60, pct);
    end
    settle();

    $display("covered %0d loads and %0d evaluates across %0d register settings",
             n_loads, n_evals, n_settings);
    $display("both curve modes, point counts 0 to 2047, full and clamped u range");
    if (fails == 0) begin
      $display("cubic_spline_point_evaluator_top_tb OK");
    end else begin
      $display("cubic_spline_point_evaluator_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cspe_pkg.sv
src/cspe_ram.sv
src/cspe_fetch.sv
src/cspe_weight.sv
src/cspe_combine.sv
src/cubic_spline_point_evaluator_top.sv
dv/cspe_checker.sv
dv/cubic_spline_point_evaluator_top_tb.sv
